@@ design/lrrc_pkg.sv @@
package lrrc_pkg;

  localparam int MAX_LEDS    = 64;
  localparam int FRAME_SLOTS = 16;
  localparam int LED_W       = 6;
  localparam int SLOT_W      = 4;
  localparam int ADDR_W      = SLOT_W + LED_W;
  localparam int PIX_W       = 24;
  localparam int CFG_W       = 22;
  localparam int CFG_IDX_W   = 3;

  localparam logic [16:0] FRAC_ONE    = 17'd100000;
  localparam logic [16:0] FRAC_ROUND  = 17'd99999;
  localparam logic [7:0]  FULL_SCALE  = 8'd255;

  // floor(x / 100000) for x < 2^25, exact with this reciprocal and shift
  localparam logic [25:0] RECIP       = 26'd43980466;
  localparam int          RECIP_SHIFT = 42;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_RATE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_STEPS = 3'd5;

  typedef struct packed {
    logic              is_tick;
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] prev;
    logic [LED_W-1:0]  shift;
    logic [16:0]       frac;
    logic [16:0]       w;
    logic [16:0]       bf;
    logic [6:0]        n;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
  } job_t;

  typedef struct packed {
    logic [LED_W-1:0] led;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic             last;
  } result_t;

  function automatic logic [7:0] div100k(input logic [24:0] x);
    logic [50:0] p;
    p = 51'(x) * 51'(RECIP);
    return p[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

endpackage

@@ design/led_ring_rotate_crossfade_render_top.sv @@
// LED ring renderer with rotation and crossfade.
// Input queue side: push/full. cmd selects a pixel write (frame_slot,
// led_index, red/green/blue), a render tick or an animation restart.
// A transaction is taken when push is high and full low.
// Result queue side: empty/pop. A render tick yields one transaction per LED
// in use (out_led, out_red/green/blue, last on the final LED).
// Configuration: cfg_we/cfg_index/cfg_data. The user must write it only while
// idle; the block does not enforce this. Flow: pixel writes and restarts
// leave the front end idle. A tick keeps full high in the front end for the
// rotation sum, then two sequential divisions (rotation modulo the ring
// length, crossfade weight). The back end picks up the job, then works each
// LED in turn through four frame store reads on one read port, then the
// multiply and divide steps and an output step. Front and back overlap
// across a four-entry job queue.
// A stalled receiver fills the four-entry result queue, which stops the
// renderer, then the job queue, then full stays high.
// Reset clears control state and loads register defaults; the frame store
// is not cleared and must be written before use.
module led_ring_rotate_crossfade_render_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      cmd,
  input  logic [lrrc_pkg::SLOT_W-1:0]     frame_slot,
  input  logic [lrrc_pkg::LED_W-1:0]      led_index,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  output logic                            empty,
  input  logic                            pop,
  output logic [lrrc_pkg::LED_W-1:0]      out_led,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic                            last,
  input  logic                            cfg_we,
  input  logic [lrrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrrc_pkg::CFG_W-1:0]      cfg_data
);
  import lrrc_pkg::*;

  logic    jq_push;
  logic    jq_full;
  logic    jq_pop;
  logic    jq_empty;
  job_t    jq_din;
  job_t    jq_dout;
  result_t res;

  lrrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .frame_slot (frame_slot),
    .led_index  (led_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .jq_push    (jq_push),
    .jq_din     (jq_din),
    .jq_full    (jq_full)
  );

  lrrc_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (jq_push),
    .din   (jq_din),
    .full  (jq_full),
    .pop   (jq_pop),
    .dout  (jq_dout),
    .empty (jq_empty)
  );

  lrrc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .jq_dout  (jq_dout),
    .jq_empty (jq_empty),
    .jq_pop   (jq_pop),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign out_led   = res.led;
  assign out_red   = res.r;
  assign out_green = res.g;
  assign out_blue  = res.b;
  assign last      = res.last;

endmodule

@@ design/lrrc_ram.sv @@
module lrrc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/lrrc_div.sv @@
module lrrc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [22:0] den,
  output logic        done,
  output logic [31:0] quo,
  output logic [22:0] rem
);

  logic        run;
  logic [4:0]  cnt;
  logic [22:0] dreg;
  logic [23:0] t;

  // restoring division, one quotient bit per cycle
  assign t = {rem, quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      rem  <= '0;
      dreg <= den;
    end else if (run) begin
      if (t >= {1'b0, dreg}) begin
        rem <= 23'(t - {1'b0, dreg});
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= t[22:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

@@ design/lrrc_jobq.sv @@
module lrrc_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lrrc_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output lrrc_pkg::job_t dout,
  output logic          empty
);
  import lrrc_pkg::*;

  job_t       q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;

  assign full  = (cnt == 3'd4);
  assign empty = (cnt == 3'd0);
  assign dout  = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) begin
        wp <= wp + 2'd1;
      end
      if (pop && !empty) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + 3'(push && !full) - 3'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q[wp] <= din;
    end
  end

endmodule

@@ design/lrrc_front.sv @@
module lrrc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      cmd,
  input  logic [lrrc_pkg::SLOT_W-1:0]     frame_slot,
  input  logic [lrrc_pkg::LED_W-1:0]      led_index,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  input  logic                            cfg_we,
  input  logic [lrrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrrc_pkg::CFG_W-1:0]      cfg_data,
  output logic                            jq_push,
  output lrrc_pkg::job_t                  jq_din,
  input  logic                            jq_full
);
  import lrrc_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_MOD  = 3'd2;
  localparam logic [2:0] F_W    = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  // 100000 / 255 split into whole and remainder parts
  localparam logic [16:0] BF_INT = 17'(FRAC_ONE / FULL_SCALE);
  localparam logic [13:0] BF_REM = 14'(FRAC_ONE % FULL_SCALE);
  // floor(y / 255) for y <= 10200
  localparam logic [30:0] R255   = 31'd65794;

  logic [6:0]  led_count;
  logic [4:0]  slot_total;
  logic [7:0]  brightness;
  logic [9:0]  frame_time_ms;
  logic [21:0] rotation_rate;
  logic [9:0]  fade_steps;

  logic [2:0]  state;
  logic [3:0]  cur;
  logic [22:0] pos;
  logic [9:0]  prog;

  logic [3:0]  prev_r;
  logic [6:0]  n_r;
  logic [9:0]  s_r;
  logic [22:0] bound;
  logic signed [32:0] prod_r;
  logic        neg;
  logic [5:0]  shift_r;
  logic [16:0] frac_r;
  logic [16:0] w_r;
  logic [16:0] bf_r;

  logic [6:0]  n_eff;
  logic [4:0]  fc_eff;
  logic [9:0]  s_eff;
  logic        adv;
  logic [3:0]  cur_adv;
  logic [3:0]  cur_nx;
  logic        take;

  logic signed [33:0] sum;
  logic [31:0] mag;
  logic [22:0] pos_fix;
  logic [9:0]  pmin;

  logic [7:0]  shift_calc;
  logic [13:0] b_rem;
  logic [30:0] b_rem_m;
  logic [16:0] bf_calc;

  logic        div_start;
  logic [31:0] div_num;
  logic [22:0] div_den;
  logic        div_done;
  logic [31:0] div_quo;
  logic [22:0] div_rem;

  assign n_eff  = (led_count == 7'd0) ? 7'd1 :
                  (led_count > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : led_count;
  assign fc_eff = (slot_total == 5'd0) ? 5'd1 :
                  (slot_total > 5'(FRAME_SLOTS)) ? 5'(FRAME_SLOTS) : slot_total;
  assign s_eff  = (fade_steps == 10'd0) ? 10'd1 : fade_steps;
  assign adv     = (s_eff <= 10'd1) || (prog <= 10'd1);
  assign cur_adv = ((5'(cur) + 5'd1) >= fc_eff) ? 4'd0 : cur + 4'd1;
  assign cur_nx  = adv ? cur_adv : cur;

  assign full = (state != F_IDLE) || jq_full;
  assign take = push && !full;

  assign sum     = 34'($signed({1'b0, pos})) + 34'(prod_r);
  assign mag     = sum[33] ? 32'(-sum) : 32'(sum);
  assign pos_fix = (neg && div_rem != 23'd0) ? bound - div_rem : div_rem;
  assign pmin    = (prog < s_r) ? prog : s_r;

  // shift settles first, frac follows from the registered shift
  assign shift_calc = div100k(25'(pos));
  assign b_rem      = 14'(brightness) * BF_REM;
  assign b_rem_m    = 31'(b_rem) * R255;
  assign bf_calc    = 17'(brightness) * BF_INT + 17'(b_rem_m[30:24]);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      F_MUL: begin
        div_start = 1'b1;
        div_num   = mag;
        div_den   = bound;
      end
      F_MOD: begin
        div_start = div_done;
        div_num   = 32'(FRAC_ONE) * 32'(pmin);
        div_den   = 23'(s_r);
      end
      default: begin
      end
    endcase
  end

  lrrc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    jq_din         = '0;
    jq_push        = 1'b0;
    if (state == F_PUSH) begin
      jq_push       = !jq_full;
      jq_din.is_tick = 1'b1;
      jq_din.cur    = cur;
      jq_din.prev   = prev_r;
      jq_din.shift  = shift_r;
      jq_din.frac   = frac_r;
      jq_din.w      = w_r;
      jq_din.bf     = bf_r;
      jq_din.n      = n_r;
    end else begin
      jq_push       = take && (cmd == CMD_WRITE);
      jq_din.addr   = {frame_slot, led_index};
      jq_din.pix    = {red, green, blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count     <= 7'd24;
      slot_total    <= 5'd1;
      brightness    <= 8'd255;
      frame_time_ms <= 10'd50;
      rotation_rate <= '0;
      fade_steps    <= 10'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LED_COUNT:   led_count     <= cfg_data[6:0];
        REG_FRAME_COUNT: slot_total    <= cfg_data[4:0];
        REG_BRIGHTNESS:  brightness    <= cfg_data[7:0];
        REG_FRAME_TIME:  frame_time_ms <= cfg_data[9:0];
        REG_ROT_RATE:    rotation_rate <= cfg_data;
        REG_TRANS_STEPS: fade_steps    <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cur   <= '0;
      pos   <= '0;
      prog  <= 10'd1;
    end else begin
      case (state)
        F_IDLE: begin
          if (take && cmd == CMD_RESTART) begin
            cur  <= '0;
            pos  <= '0;
            prog <= s_eff;
          end else if (take && cmd == CMD_TICK) begin
            cur   <= cur_nx;
            if (adv) begin
              prog <= s_eff;
            end
            state <= F_MUL;
          end
        end
        F_MUL: state <= F_MOD;
        F_MOD: begin
          if (div_done) begin
            pos   <= pos_fix;
            state <= F_W;
          end
        end
        F_W: if (div_done) state <= F_PUSH;
        F_PUSH: begin
          if (!jq_full) begin
            if (prog != 10'd0) begin
              prog <= prog - 10'd1;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      prev_r <= (cur_nx == 4'd0) ? 4'(fc_eff - 5'd1) : cur_nx - 4'd1;
      n_r    <= n_eff;
      s_r    <= s_eff;
      bound  <= 23'(n_eff) * 23'(FRAC_ONE);
      prod_r <= $signed(rotation_rate) * $signed({1'b0, frame_time_ms});
    end
    if (state == F_MUL) begin
      neg <= sum[33];
    end
    if (state == F_W) begin
      shift_r <= shift_calc[5:0];
      frac_r  <= 17'(pos - 23'(shift_r) * 23'(FRAC_ONE));
      bf_r    <= bf_calc;
      if (div_done) begin
        w_r <= div_quo[16:0];
      end
    end
  end

endmodule

@@ design/lrrc_back.sv @@
module lrrc_back (
  input  logic                clk,
  input  logic                rst,
  input  lrrc_pkg::job_t      jq_dout,
  input  logic                jq_empty,
  output logic                jq_pop,
  input  logic                pop,
  output logic                empty,
  output lrrc_pkg::result_t   res
);
  import lrrc_pkg::*;

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_RD0  = 4'd1;
  localparam logic [3:0] B_RD1  = 4'd2;
  localparam logic [3:0] B_RD2  = 4'd3;
  localparam logic [3:0] B_RD3  = 4'd4;
  localparam logic [3:0] B_MA   = 4'd5;
  localparam logic [3:0] B_DA   = 4'd6;
  localparam logic [3:0] B_MB   = 4'd7;
  localparam logic [3:0] B_DB   = 4'd8;
  localparam logic [3:0] B_MC   = 4'd9;
  localparam logic [3:0] B_DC   = 4'd10;
  localparam logic [3:0] B_OUT  = 4'd11;

  logic [3:0]       state;
  job_t             job;
  logic [LED_W-1:0] i;
  logic [LED_W-1:0] j;
  logic [LED_W-1:0] k;
  logic             last_led;

  logic [PIX_W-1:0] pk;
  logic [PIX_W-1:0] pj;
  logic [PIX_W-1:0] ck;
  logic [24:0]      xa [3];
  logic [24:0]      xb [3];
  logic [7:0]       la [3];
  logic [7:0]       lb [3];
  logic [7:0]       mix [3];
  logic [7:0]       ov [3];

  logic              ram_we;
  logic [ADDR_W-1:0] raddr;
  logic [PIX_W-1:0]  rdata;

  result_t    oq [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       oq_full;
  logic       oq_push;

  assign k        = (7'(j) + 7'd1 == job.n) ? '0 : j + 1'b1;
  assign last_led = (7'(i) + 7'd1 == job.n);

  assign jq_pop = (state == B_IDLE) && !jq_empty;
  assign ram_we = jq_pop && !jq_dout.is_tick;

  always_comb begin
    case (state)
      B_RD0:   raddr = {job.prev, k};
      B_RD1:   raddr = {job.prev, j};
      B_RD2:   raddr = {job.cur, k};
      default: raddr = {job.cur, j};
    endcase
  end

  lrrc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_SLOTS * MAX_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (jq_dout.addr),
    .wdata (jq_dout.pix),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: if (jq_pop && jq_dout.is_tick) state <= B_RD0;
        B_RD0:  state <= B_RD1;
        B_RD1:  state <= B_RD2;
        B_RD2:  state <= B_RD3;
        B_RD3:  state <= B_MA;
        B_MA:   state <= B_DA;
        B_DA:   state <= B_MB;
        B_MB:   state <= B_DB;
        B_DB:   state <= B_MC;
        B_MC:   state <= B_DC;
        B_DC:   state <= B_OUT;
        B_OUT: begin
          if (!oq_full) begin
            state <= last_led ? B_IDLE : B_RD0;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // channel lanes: 0 red, 1 green, 2 blue
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (jq_pop) begin
          job <= jq_dout;
          i   <= '0;
          j   <= jq_dout.shift;
        end
      end
      B_RD1: pk <= rdata;
      B_RD2: pj <= rdata;
      B_RD3: ck <= rdata;
      B_MA: begin
        for (int c = 0; c < 3; c++) begin
          xa[c] <= 25'(pk[23-8*c -: 8]) * 25'(job.frac)
                 + 25'(pj[23-8*c -: 8]) * 25'(FRAC_ONE - job.frac);
          xb[c] <= 25'(ck[23-8*c -: 8]) * 25'(job.frac)
                 + 25'(rdata[23-8*c -: 8]) * 25'(FRAC_ONE - job.frac);
        end
      end
      B_DA: begin
        for (int c = 0; c < 3; c++) begin
          la[c] <= div100k(xa[c]);
          lb[c] <= div100k(xb[c]);
        end
      end
      B_MB: begin
        for (int c = 0; c < 3; c++) begin
          xa[c] <= 25'(la[c]) * 25'(job.w) + 25'(lb[c]) * 25'(FRAC_ONE - job.w);
        end
      end
      B_DB: begin
        for (int c = 0; c < 3; c++) begin
          mix[c] <= div100k(xa[c]);
        end
      end
      B_MC: begin
        // ceiling via floor of (x + 99999)
        for (int c = 0; c < 3; c++) begin
          xa[c] <= 25'(mix[c]) * 25'(job.bf) + 25'(FRAC_ROUND);
        end
      end
      B_DC: begin
        for (int c = 0; c < 3; c++) begin
          ov[c] <= div100k(xa[c]);
        end
      end
      B_OUT: begin
        if (!oq_full) begin
          i <= i + 1'b1;
          j <= k;
        end
      end
      default: begin
      end
    endcase
  end

  assign oq_full = (cnt == 3'd4);
  assign oq_push = (state == B_OUT) && !oq_full;
  assign empty   = (cnt == 3'd0);
  assign res     = oq[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (oq_push) begin
        wp <= wp + 2'd1;
      end
      if (pop && !empty) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + 3'(oq_push) - 3'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[wp] <= '{led: i, r: ov[0], g: ov[1], b: ov[2], last: last_led};
    end
  end

endmodule

@@ design/lrrc_chk.sv @@
module lrrc_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [lrrc_pkg::LED_W-1:0]  out_led,
  input logic                        last
);
  import lrrc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_led) && $stable(last))
    else $error("waiting result changed");

  a_led_seq: assert property (@(posedge clk) disable iff (rst)
    pop && !empty && !last |=> empty || out_led == LED_W'($past(out_led) + 1'b1))
    else $error("LED order broken within frame");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    pop && !empty && last |=> empty || out_led == '0)
    else $error("frame does not start at LED 0");

endmodule

bind led_ring_rotate_crossfade_render_top lrrc_chk u_chk (
  .clk     (clk),
  .rst     (rst),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .out_led (out_led),
  .last    (last)
);
